### hdl/assert_macros.svh
// Assertion helpers shared by the streaming selection RTL.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/stks_pkg.sv
// Shared types and constants for the streaming largest-score selection block.
// No dependencies; imported by the cell, the interfaces and the top level.
package stks_pkg;

	localparam int SCORE_W      = 32;
	localparam int IDX_W        = 12;
	localparam int KEEP_W       = 5;
	localparam int MAX_KEEP_DEF = 16;
	localparam int MAX_ROW_DEF  = 4096;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [KEEP_W-1:0]         keep_t;

	localparam score_t SCORE_MIN  = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam keep_t  KEEP_RESET = KEEP_W'(16);

	// Per-slot control from the top level
	typedef struct packed {
		logic ins;      // insert the incoming score this cycle
		logic clr;      // return slot to its empty value
		logic active;   // slot lies inside the working range
		logic is_last;  // slot is the last one of the working range
	} cell_ctrl_t;

	// What a cell shows to its right-hand neighbour and to the top level
	typedef struct packed {
		logic   ge;     // held score >= incoming score
		logic   gt;     // held score >  incoming score
		score_t score;
		idx_t   pos;
	} cell_link_t;

endpackage

### hdl/stks_in_if.sv
// Score input channel: valid/ready handshake carrying one score per item.
// Depends on stks_pkg for the payload types.
interface stks_in_if;
	import stks_pkg::*;

	logic   valid;
	logic   ready;
	score_t score;
	logic   row_end;

	modport source (output valid, output score, output row_end, input ready);
	modport sink   (input valid, input score, input row_end, output ready);
endinterface

### hdl/stks_out_if.sv
// Result output channel: valid/ready handshake carrying one kept entry per item.
// Depends on stks_pkg for the payload types.
interface stks_out_if;
	import stks_pkg::*;

	logic   valid;
	logic   ready;
	score_t score_out;
	idx_t   index_out;
	logic   last;

	modport source (output valid, output score_out, output index_out, output last,
		input ready);
	modport sink   (input valid, input score_out, input index_out, input last,
		output ready);
endinterface

### hdl/stks_cell.sv
// One slot of the insertion chain: holds a score and its row position.
// Depends on stks_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stks_cell #(
	parameter int SLOT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stks_pkg::cell_ctrl_t ctrl,
	input  stks_pkg::score_t    new_score,
	input  stks_pkg::idx_t      new_pos,
	input  stks_pkg::cell_link_t left,
	output stks_pkg::cell_link_t self,
	input  logic                carry_in,
	output logic                carry_out
);
	import stks_pkg::*;

	score_t score_q;
	idx_t   pos_q;
	logic   ge;
	logic   gt;
	logic   hit;

	// Compare against the incoming score; the carry tells whether some slot
	// at or right of this one still stops the shift, so this slot stays put
	always_comb begin
		ge        = score_q >= new_score;
		gt        = score_q > new_score;
		carry_out = (ctrl.active && !ctrl.is_last && ge) || carry_in;
		hit       = (SLOT == 0) ? 1'b1 : left.ge;
	end

	assign self = '{ge: ge, gt: gt, score: score_q, pos: pos_q};

	// Slot update: clear, keep, take the new score, or take the left neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= SCORE_MIN;
			pos_q   <= IDX_W'(SLOT);
		end else if (ctrl.clr) begin
			score_q <= SCORE_MIN;
			pos_q   <= IDX_W'(SLOT);
		end else if (ctrl.ins && ctrl.active && !carry_out) begin
			if (hit) begin
				score_q <= new_score;
				pos_q   <= new_pos;
			end else begin
				score_q <= left.score;
				pos_q   <= left.pos;
			end
		end
	end

	`AST_PROP(a_cell_hold, (!ctrl.clr && !(ctrl.ins && ctrl.active)) |=> ($stable(score_q) && $stable(pos_q)), "slot changed without insert or clear")

endmodule

### hdl/streaming_top_k_select.sv
// Streaming selection: a chain of insertion cells keeps the largest scores of a row.
// Depends on stks_pkg, stks_in_if, stks_out_if, stks_cell and assert_macros.svh.
// One score is accepted per cycle while a row streams in.
// After a row end, the emit state and the output register pass keep_count items out, one per
// cycle while the sink is ready, with input held off meanwhile.
// Reset (arst_n low, asynchronous) empties every slot at once and sets keep_count to 16.
`include "assert_macros.svh"

module streaming_top_k_select #(
	parameter int MAX_KEEP = stks_pkg::MAX_KEEP_DEF,
	parameter int MAX_ROW  = stks_pkg::MAX_ROW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  stks_pkg::keep_t   cfg_wr_data,
	stks_in_if.sink           scores,
	stks_out_if.source        results
);
	import stks_pkg::*;

	localparam int SLOT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int POS_W    = $clog2(MAX_ROW);
	localparam int POS_LAST = MAX_ROW - 1;

	typedef enum logic {ST_FILL, ST_EMIT} state_t;

	state_t            state_q;
	keep_t             keep_q;
	keep_t             k_eff;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] e_q;
	logic [SLOT_W-1:0] last_slot;
	logic              fill;
	logic              drop;
	logic              accept;
	logic              ins;
	logic              emit_load;
	logic              emit_last;
	logic              clr;

	logic              out_valid_q;
	score_t            res_score_q;
	idx_t              res_index_q;
	logic              res_last_q;

	cell_ctrl_t        ctrl  [MAX_KEEP];
	cell_link_t        links [MAX_KEEP];
	logic [MAX_KEEP:0] carry;
	logic [MAX_KEEP-1:0] gt_vec;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_wr_en) begin
			keep_q <= cfg_wr_data;
		end
	end

	// Effective keep count, clamped to 1..MAX_KEEP
	always_comb begin
		priority if (keep_q == '0) begin
			k_eff = KEEP_W'(1);
		end else if (32'(keep_q) > MAX_KEEP) begin
			k_eff = KEEP_W'(MAX_KEEP);
		end else begin
			k_eff = keep_q;
		end
	end

	// Working range: grows with the row until it reaches the keep count
	always_comb begin
		fill      = 32'(pos_q) < 32'(k_eff);
		last_slot = fill ? SLOT_W'(32'(pos_q)) : SLOT_W'(32'(k_eff) - 32'd1);
		drop      = !fill && gt_vec[last_slot];
		accept    = scores.valid && scores.ready;
		ins       = accept && !drop;
		emit_load = (state_q == ST_EMIT) && (!out_valid_q || results.ready);
		emit_last = 32'(e_q) == (32'(k_eff) - 32'd1);
		clr       = emit_load && emit_last;
	end

	assign scores.ready  = (state_q == ST_FILL);
	assign carry[MAX_KEEP] = 1'b0;

	// Chain of slots; the carry runs from the tail towards slot 0
	for (genvar j = 0; j < MAX_KEEP; j++) begin : g_slot
		cell_link_t left_link;

		assign ctrl[j] = '{
			ins:     ins,
			clr:     clr,
			active:  32'(last_slot) >= j,
			is_last: 32'(last_slot) == j
		};
		assign gt_vec[j] = links[j].gt;

		if (j == 0) begin : g_head
			assign left_link = '{ge: 1'b1, gt: 1'b1, score: SCORE_MIN, pos: '0};
		end else begin : g_body
			assign left_link = links[j-1];
		end

		stks_cell #(.SLOT(j)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[j]),
			.new_score (scores.score),
			.new_pos   (IDX_W'(pos_q)),
			.left      (left_link),
			.self      (links[j]),
			.carry_in  (carry[j+1]),
			.carry_out (carry[j])
		);
	end

	// Row sequencer, position counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			pos_q       <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (results.ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						if (32'(pos_q) != POS_LAST) begin
							pos_q <= pos_q + POS_W'(1);
						end
						if (scores.row_end) begin
							state_q <= ST_EMIT;
							e_q     <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						if (emit_last) begin
							state_q <= ST_FILL;
							pos_q   <= '0;
						end else begin
							e_q <= e_q + SLOT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// Result payload, loaded from the slot picked by the emit counter
	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_score_q <= links[e_q].score;
			res_index_q <= links[e_q].pos;
			res_last_q  <= emit_last;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.score_out = res_score_q;
	assign results.index_out = res_index_q;
	assign results.last      = res_last_q;

	`AST_PROP(a_row_end_emit, (scores.valid && scores.ready && scores.row_end) |=> (state_q == ST_EMIT && e_q == '0), "row end did not start emission")
	`AST_PROP(a_emit_clears, (emit_load && emit_last) |=> (pos_q == '0 && state_q == ST_FILL && results.valid && results.last), "final item did not clear the row")
	`AST_NEVER(a_pos_range, 32'(pos_q) > POS_LAST, "row position beyond saturation")

endmodule

### tb/streaming_top_k_select_tb.sv
// Testbench for streaming_top_k_select: a score stream with random row lengths and register settings.
// Keeps its own ranking of each row and checks every emitted item against it.
// Depends on stks_pkg, stks_in_if, stks_out_if and the RTL top level.
`timescale 1ns / 1ps

module streaming_top_k_select_tb;
	import stks_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RANDOM_ITEMS = 430;
	localparam score_t SCORE_TOP = 32'sh7FFF_FFFF;

	// One kept entry as the block should report it
	typedef struct {
		score_t score;
		idx_t   pos;
		logic   last;
	} kept_entry_t;

	// Ranking of the current row plus the queue of entries still owed by the block
	class row_ranking;
		score_t      ranked_score[MAX_KEEP_DEF];
		idx_t        ranked_pos[MAX_KEEP_DEF];
		int unsigned row_position;
		keep_t       keep_setting;
		kept_entry_t expected_entries[$];
		int unsigned mismatches;
		int unsigned entries_checked;

		function new();
			keep_setting = KEEP_RESET;
			mismatches = 0;
			entries_checked = 0;
			clear_row();
		endfunction

		function void clear_row();
			for (int s = 0; s < MAX_KEEP_DEF; s++) begin
				ranked_score[s] = SCORE_MIN;
				ranked_pos[s] = idx_t'(s);
			end
			row_position = 0;
		endfunction

		// 0 behaves as 1, anything above the slot count as the slot count
		function int unsigned active_keep();
			if (keep_setting == 0)
				return 1;
			if (keep_setting > MAX_KEEP_DEF)
				return MAX_KEEP_DEF;
			return keep_setting;
		endfunction

		// Accepted score: insert it, and on a row end queue the whole list
		function void note_score(score_t s, logic row_end);
			int unsigned k;
			int unsigned n;
			int unsigned j;
			idx_t        pos;
			bit          placed;
			kept_entry_t e;

			k = active_keep();
			pos = idx_t'(row_position);
			// while the row is shorter than k only the first slots take part
			if (row_position < k) begin
				n = row_position + 1;
				ranked_score[row_position] = SCORE_MIN;
			end else begin
				n = k;
			end
			// ties with the tail replace it; earlier equal scores stay ahead
			if (s >= ranked_score[n-1]) begin
				placed = 0;
				j = n - 1;
				while (j > 0 && !placed) begin
					if (s > ranked_score[j-1]) begin
						ranked_score[j] = ranked_score[j-1];
						ranked_pos[j] = ranked_pos[j-1];
						j--;
					end else begin
						ranked_score[j] = s;
						ranked_pos[j] = pos;
						placed = 1;
					end
				end
				if (!placed) begin
					ranked_score[0] = s;
					ranked_pos[0] = pos;
				end
			end
			// position counter saturates at the last index
			if (row_position < MAX_ROW_DEF - 1)
				row_position++;
			if (row_end) begin
				for (int i = 0; i < k; i++) begin
					e.score = ranked_score[i];
					e.pos = ranked_pos[i];
					e.last = (i == k - 1);
					expected_entries.push_back(e);
				end
				clear_row();
			end
		endfunction

		// Emitted item against the oldest entry owed
		function void check_entry(score_t s, idx_t p, logic l);
			kept_entry_t e;

			entries_checked++;
			if (expected_entries.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item score=%0d index=%0d last=%0b", $time, s, p, l);
				return;
			end
			e = expected_entries.pop_front();
			if (s !== e.score) begin
				mismatches++;
				$display("%0t: score_out expected %0d got %0d", $time, e.score, s);
			end
			if (p !== e.pos) begin
				mismatches++;
				$display("%0t: index_out expected %0d got %0d", $time, e.pos, p);
			end
			if (l !== e.last) begin
				mismatches++;
				$display("%0t: last expected %0b got %0b", $time, e.last, l);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	keep_t       cfg_wr_data;
	bit          no_idle;
	int unsigned scores_sent;
	int unsigned cycle_count;
	row_ranking  ranking;

	stks_in_if  in_ch ();
	stks_out_if out_ch ();

	streaming_top_k_select dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.scores      (in_ch),
		.results     (out_ch)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic score_t rand_score();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 50)
			return score_t'($urandom);
		// narrow band so that ties are common
		if (r < 85)
			return score_t'(int'($urandom_range(0, 8)) - 4);
		case ($urandom_range(0, 4))
			0: return SCORE_MIN;
			1: return SCORE_TOP;
			2: return score_t'(0);
			3: return score_t'(-1);
			default: return SCORE_MIN + 1;
		endcase
	endfunction

	function automatic keep_t pick_keep();
		if ($urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 3))
				0: return keep_t'(0);
				1: return keep_t'(1);
				2: return keep_t'(16);
				default: return keep_t'(31);
			endcase
		end
		return keep_t'($urandom_range(0, 31));
	endfunction

	function automatic int unsigned pick_row_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 24);
		return $urandom_range(25, 80);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_score(input score_t s, input logic row_end);
		int unsigned gap;

		gap = no_idle ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.score <= s;
		in_ch.row_end <= row_end;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		ranking.note_score(s, row_end);
		scores_sent++;
	endtask

	task automatic send_row(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_score(rand_score(), i == len - 1);
	endtask

	task automatic stop_offering();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// All owed items in, then a margin for the emitter to settle
	task automatic wait_until_idle();
		while (ranking.expected_entries.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_keep(input keep_t v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		ranking.keep_setting = v;
	endtask

	// Result sink: random stalls, and one long hold-off to back the block up
	initial begin
		int unsigned stall_left;
		bit          long_hold_done;

		stall_left = 0;
		long_hold_done = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && ranking.entries_checked >= 150 && out_ch.valid) begin
				stall_left = 300;
				long_hold_done = 1;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (no_idle || $urandom_range(0, 99) < 70) begin
				out_ch.ready <= 1'b1;
			end else begin
				stall_left = (($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
					$urandom_range(1, 3)) - 1;
				out_ch.ready <= 1'b0;
			end
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				ranking.check_entry(out_ch.score_out, out_ch.index_out, out_ch.last);
		end
	end

	// Stimulus
	initial begin
		bit first_phase;

		ranking = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.score = '0;
		in_ch.row_end = 1'b0;
		no_idle = 0;
		scores_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: a one-score row leaves most slots empty
		send_score(SCORE_TOP, 1'b1);
		// scores equal to the empty value
		send_score(SCORE_MIN, 1'b0);
		send_score(SCORE_MIN, 1'b0);
		send_score(SCORE_MIN, 1'b1);
		// equal scores keep arrival order
		send_score(score_t'(10), 1'b0);
		send_score(score_t'(10), 1'b0);
		send_score(score_t'(20), 1'b0);
		send_score(score_t'(10), 1'b0);
		send_score(score_t'(-1), 1'b1);
		stop_offering();
		wait_until_idle();

		// single slot: drop, tie replaces, larger replaces
		write_keep(keep_t'(1));
		send_score(score_t'(5), 1'b0);
		send_score(score_t'(3), 1'b0);
		send_score(score_t'(5), 1'b0);
		send_score(score_t'(7), 1'b0);
		send_score(score_t'(6), 1'b1);
		stop_offering();
		wait_until_idle();

		// zero behaves as one
		write_keep(keep_t'(0));
		send_score(score_t'(0), 1'b0);
		send_score(score_t'(-1), 1'b1);
		stop_offering();
		wait_until_idle();

		write_keep(keep_t'(2));
		send_score(score_t'(1), 1'b0);
		send_score(score_t'(2), 1'b0);
		send_score(score_t'(2), 1'b0);
		send_score(score_t'(1), 1'b1);

		// random phases, each with its own setting and idling style
		first_phase = 1;
		while (scores_sent < RANDOM_ITEMS) begin
			stop_offering();
			wait_until_idle();
			write_keep(first_phase ? keep_t'(31) : pick_keep());
			first_phase = 0;
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 4))
				send_row(pick_row_len());
		end
		no_idle = 0;
		stop_offering();

		while (ranking.expected_entries.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (ranking.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/stks_pkg.sv
hdl/stks_in_if.sv
hdl/stks_out_if.sv
hdl/stks_cell.sv
hdl/streaming_top_k_select.sv
tb/streaming_top_k_select_tb.sv
